// ----- rtl/ssp_pkg.sv -----
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants of the star projector
// Star entry, pipeline payloads, divider step and configuration codes.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int unsigned STAR_COUNT = 256;
  localparam int unsigned IDX_W      = $clog2(STAR_COUNT);
  localparam int unsigned DIV_STAGES = 18;
  localparam int unsigned DIV_LANES  = 3;
  localparam int unsigned FIFO_DEPTH = 32;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned BRIGHT_SCALE = 235;

  localparam int unsigned LANE_X = 0;
  localparam int unsigned LANE_Y = 1;
  localparam int unsigned LANE_B = 2;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

  typedef struct packed {
    logic signed [8:0] x;
    logic signed [8:0] y;
    logic [9:0]        z;
  } star_t;

  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  idx;
    logic signed [8:0] x;
    logic signed [8:0] y;
    logic [9:0]        z;
  } item_t;

  typedef struct packed {
    logic  draw;
    star_t star;
  } proj_t;

  typedef struct packed {
    logic [17:0] num;
    logic [9:0]  den;
    logic [9:0]  rem;
    logic [17:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic draw;
    logic x_neg;
    logic y_neg;
  } meta_t;

  typedef struct packed {
    logic [17:0] addr;
    logic [15:0] color;
    logic        vis;
  } res_t;

  function automatic div_lane_t div_step(div_lane_t l);
    logic [10:0] t;
    logic [10:0] diff;
    logic        ge;
    div_lane_t   r;
    t    = {l.rem, l.num[17]};
    diff = t - {1'b0, l.den};
    ge   = (t >= {1'b0, l.den});
    r.num = {l.num[16:0], 1'b0};
    r.den = l.den;
    r.rem = ge ? diff[9:0] : t[9:0];
    r.quo = {l.quo[16:0], ge};
    return r;
  endfunction

endpackage

// ----- rtl/ssp_star_mem.sv -----
// ----------------------------------------------------------------------------
// ssp_star_mem: star table with read-modify-write
// Reads the entry on accept, updates or loads it in the following cycle and
// forwards the last write to a following transaction on the same entry.
// ----------------------------------------------------------------------------
module ssp_star_mem (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  ssp_pkg::item_t req_i,
  input  logic [9:0]     width_i,
  output logic           proj_valid_o,
  output ssp_pkg::proj_t proj_o
);

  ssp_pkg::star_t mem_q [ssp_pkg::STAR_COUNT];
  ssp_pkg::star_t rdata_q;
  logic           s1_valid_q;
  ssp_pkg::item_t s1_q;
  logic           fwd_valid_q;
  logic [ssp_pkg::IDX_W-1:0] fwd_idx_q;
  ssp_pkg::star_t fwd_data_q;
  logic           proj_valid_q;
  ssp_pkg::proj_t proj_q;

  ssp_pkg::star_t cur;
  ssp_pkg::star_t adv;
  ssp_pkg::star_t wr_data;
  logic           respawn;

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      rdata_q <= mem_q[req_i.idx];
    end
    if (s1_valid_q) begin
      mem_q[s1_q.idx] <= wr_data;
    end
  end

  always_comb begin
    cur     = (fwd_valid_q && (fwd_idx_q == s1_q.idx)) ? fwd_data_q : rdata_q;
    respawn = (cur.z <= 10'd1);
    if (respawn) begin
      adv.x = s1_q.x;
      adv.y = s1_q.y;
      adv.z = width_i;
    end else begin
      adv.x = cur.x;
      adv.y = cur.y;
      adv.z = cur.z - 10'd1;
    end
    if (s1_q.op == ssp_pkg::OP_LOAD) begin
      wr_data.x = s1_q.x;
      wr_data.y = s1_q.y;
      wr_data.z = s1_q.z;
    end else begin
      wr_data = adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      fwd_valid_q  <= 1'b0;
      proj_valid_q <= 1'b0;
    end else begin
      s1_valid_q   <= req_valid_i;
      fwd_valid_q  <= s1_valid_q;
      proj_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q        <= req_i;
    fwd_idx_q   <= s1_q.idx;
    fwd_data_q  <= wr_data;
    proj_q.draw <= (s1_q.op == ssp_pkg::OP_ADVANCE) && (adv.z != 10'd0);
    proj_q.star <= adv;
  end

  assign proj_valid_o = proj_valid_q;
  assign proj_o       = proj_q;

endmodule

// ----- rtl/ssp_div_pipe.sv -----
// ----------------------------------------------------------------------------
// ssp_div_pipe: pipelined restoring divider, three lanes
// One quotient bit per stage; takes a new transaction every cycle.
// ----------------------------------------------------------------------------
module ssp_div_pipe (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  input  ssp_pkg::div_lane_t [ssp_pkg::DIV_LANES-1:0] lane_i,
  input  ssp_pkg::meta_t                            meta_i,
  output logic                                      out_valid_o,
  output ssp_pkg::div_lane_t [ssp_pkg::DIV_LANES-1:0] lane_o,
  output ssp_pkg::meta_t                            meta_o
);

  logic [ssp_pkg::DIV_STAGES:0]                valid_q;
  ssp_pkg::div_lane_t [ssp_pkg::DIV_LANES-1:0] lane_q [ssp_pkg::DIV_STAGES+1];
  ssp_pkg::meta_t                              meta_q [ssp_pkg::DIV_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[ssp_pkg::DIV_STAGES-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q[0] <= lane_i;
    meta_q[0] <= meta_i;
  end

  for (genvar g = 1; g <= ssp_pkg::DIV_STAGES; g++) begin : g_stage
    always_ff @(posedge clk_i) begin
      for (int l = 0; l < ssp_pkg::DIV_LANES; l++) begin
        lane_q[g][l] <= ssp_pkg::div_step(lane_q[g-1][l]);
      end
      meta_q[g] <= meta_q[g-1];
    end
  end

  assign out_valid_o = valid_q[ssp_pkg::DIV_STAGES];
  assign lane_o      = lane_q[ssp_pkg::DIV_STAGES];
  assign meta_o      = meta_q[ssp_pkg::DIV_STAGES];

endmodule

// ----- rtl/ssp_out_fifo.sv -----
// ----------------------------------------------------------------------------
// ssp_out_fifo: result queue
// Holds finished pixels while the receiver stalls.
// ----------------------------------------------------------------------------
module ssp_out_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ssp_pkg::res_t push_data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output ssp_pkg::res_t data_o
);

  ssp_pkg::res_t                 mem_q [ssp_pkg::FIFO_DEPTH];
  logic [ssp_pkg::FIFO_AW-1:0]   wr_ptr_q;
  logic [ssp_pkg::FIFO_AW-1:0]   rd_ptr_q;
  logic [ssp_pkg::FIFO_AW:0]     count_q;
  logic [ssp_pkg::FIFO_AW:0]     count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

// ----- rtl/starfield_star_projector.sv -----
// ----------------------------------------------------------------------------
// starfield_star_projector: 3D starfield star update and projection
// Input channel (in_valid_i/in_stall_o) carries one transaction per star:
// a load writes the table entry and yields an invisible pixel, an advance
// moves the star one step closer, respawns it at depth screen_width when it
// passes the viewer and yields its projected pixel address and grey color.
// Output channel (out_valid_o/out_stall_i) gives one pixel per transaction,
// in order. A transaction is taken every cycle while in_stall_o is low; each
// result passes the table read-modify-write, the divider's input register
// and its 18 stages, two projection stages and the queue write.
// Results wait in a 32-entry queue;
// a credit count of transactions in flight raises in_stall_o when the
// queue could not take them all, so a stalled receiver stops the input
// after at most 32 outstanding transactions and nothing is lost.
// Reset empties the pipeline and queue and sets width 240 and height 320;
// the star table holds no defined value until each entry is loaded.
// Registers (APB): 0x0 screen_width, 0x4 screen_height.
// ----------------------------------------------------------------------------
module starfield_star_projector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  star_index_i,
  input  logic signed [8:0] new_x_i,
  input  logic signed [8:0] new_y_i,
  input  logic [9:0]  new_depth_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [17:0] pixel_address_o,
  output logic [15:0] pixel_color_o,
  output logic        pixel_visible_o
);

  logic [9:0] width_q;
  logic [9:0] height_q;
  logic [ssp_pkg::FIFO_AW:0] credit_q;
  logic [ssp_pkg::FIFO_AW:0] credit_d;
  logic accept;
  logic pop;
  ssp_pkg::reg_e reg_sel;

  ssp_pkg::item_t req;
  logic           proj_valid;
  ssp_pkg::proj_t proj;

  logic signed [19:0] xw;
  logic signed [19:0] yw;
  logic [19:0]        xw_abs;
  logic [19:0]        yw_abs;
  logic [9:0]         z_m1;
  logic [17:0]        bnum;
  ssp_pkg::div_lane_t [ssp_pkg::DIV_LANES-1:0] div_in;
  ssp_pkg::meta_t     meta_in;

  logic               div_valid;
  ssp_pkg::div_lane_t [ssp_pkg::DIV_LANES-1:0] div_out;
  ssp_pkg::meta_t     meta_out;

  logic signed [18:0] sx;
  logic signed [18:0] sy;
  logic               vis;
  logic [7:0]         bright;

  logic        f1_valid_q;
  logic        f1_vis_q;
  logic [9:0]  f1_sx_q;
  logic [9:0]  f1_sy_q;
  logic [15:0] f1_color_q;

  logic          f2_valid_q;
  ssp_pkg::res_t f2_res_q;
  logic [19:0]   addr_full;

  ssp_pkg::res_t out_res;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = ssp_pkg::reg_e'(paddr[2]);

  always_comb begin
    case (reg_sel)
      ssp_pkg::REG_WIDTH:  prdata = {22'd0, width_q};
      ssp_pkg::REG_HEIGHT: prdata = {22'd0, height_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 10'd240;
      height_q <= 10'd320;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        ssp_pkg::REG_WIDTH:  width_q  <= pwdata[9:0];
        ssp_pkg::REG_HEIGHT: height_q <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // credit count of transactions not yet delivered
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;
  assign in_stall_o = (credit_q >= (ssp_pkg::FIFO_AW+1)'(ssp_pkg::FIFO_DEPTH));

  always_comb begin
    credit_d = credit_q;
    if (accept && !pop) begin
      credit_d = credit_q + 1'b1;
    end else if (pop && !accept) begin
      credit_d = credit_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

  // star table
  assign req.op  = ssp_pkg::op_e'(operation_i);
  assign req.idx = star_index_i;
  assign req.x   = new_x_i;
  assign req.y   = new_y_i;
  assign req.z   = new_depth_i;

  ssp_star_mem u_star_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (accept),
    .req_i        (req),
    .width_i      (width_q),
    .proj_valid_o (proj_valid),
    .proj_o       (proj)
  );

  // scale by width and form the divider operands
  always_comb begin
    xw     = $signed({{11{proj.star.x[8]}}, proj.star.x}) * $signed({10'd0, width_q});
    yw     = $signed({{11{proj.star.y[8]}}, proj.star.y}) * $signed({10'd0, width_q});
    xw_abs = xw[19] ? 20'(-xw) : 20'(xw);
    yw_abs = yw[19] ? 20'(-yw) : 20'(yw);
    z_m1   = proj.star.z - 10'd1;
    bnum   = 18'({8'd0, z_m1} * 18'(ssp_pkg::BRIGHT_SCALE));

    div_in[ssp_pkg::LANE_X].num = xw_abs[18:1];
    div_in[ssp_pkg::LANE_X].den = proj.star.z;
    div_in[ssp_pkg::LANE_X].rem = '0;
    div_in[ssp_pkg::LANE_X].quo = '0;
    div_in[ssp_pkg::LANE_Y].num = yw_abs[18:1];
    div_in[ssp_pkg::LANE_Y].den = proj.star.z;
    div_in[ssp_pkg::LANE_Y].rem = '0;
    div_in[ssp_pkg::LANE_Y].quo = '0;
    div_in[ssp_pkg::LANE_B].num = bnum;
    div_in[ssp_pkg::LANE_B].den = width_q - 10'd1;
    div_in[ssp_pkg::LANE_B].rem = '0;
    div_in[ssp_pkg::LANE_B].quo = '0;

    meta_in.draw  = proj.draw;
    meta_in.x_neg = xw[19];
    meta_in.y_neg = yw[19];
  end

  ssp_div_pipe u_div_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (proj_valid),
    .lane_i      (div_in),
    .meta_i      (meta_in),
    .out_valid_o (div_valid),
    .lane_o      (div_out),
    .meta_o      (meta_out)
  );

  // screen position, clipping and color
  always_comb begin
    sx = (meta_out.x_neg ? -$signed({1'b0, div_out[ssp_pkg::LANE_X].quo})
                         :  $signed({1'b0, div_out[ssp_pkg::LANE_X].quo}))
         + $signed({10'd0, width_q[9:1]});
    sy = (meta_out.y_neg ? -$signed({1'b0, div_out[ssp_pkg::LANE_Y].quo})
                         :  $signed({1'b0, div_out[ssp_pkg::LANE_Y].quo}))
         + $signed({10'd0, height_q[9:1]});
    vis = meta_out.draw && !sx[18] && !sy[18]
          && (sx < $signed({9'd0, width_q})) && (sy < $signed({9'd0, height_q}));
    bright = (width_q >= 10'd2) ? (8'd255 - div_out[ssp_pkg::LANE_B].quo[7:0]) : 8'd255;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= div_valid;
      f2_valid_q <= f1_valid_q;
    end
  end

  assign addr_full = {10'd0, f1_sx_q} + ({10'd0, f1_sy_q} * {10'd0, width_q});

  always_ff @(posedge clk_i) begin
    f1_vis_q       <= vis;
    f1_sx_q        <= sx[9:0];
    f1_sy_q        <= sy[9:0];
    f1_color_q     <= {bright[7:3], bright[7:2], bright[7:3]};
    f2_res_q.vis   <= f1_vis_q;
    f2_res_q.addr  <= f1_vis_q ? addr_full[17:0] : 18'd0;
    f2_res_q.color <= f1_vis_q ? f1_color_q : 16'd0;
  end

  ssp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f2_valid_q),
    .push_data_i (f2_res_q),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .data_o      (out_res)
  );

  assign pixel_address_o = out_res.addr;
  assign pixel_color_o   = out_res.color;
  assign pixel_visible_o = out_res.vis;

endmodule

// ----- sim/ssp_checker.sv -----
// ----------------------------------------------------------------------------
// ssp_checker: pixel predictor and scoreboard for the star projector
// Watches register writes and both channels, keeps its own star table and
// screen size, predicts the pixel of every accepted star transaction and
// compares each accepted pixel, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module ssp_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              operation_i,
  input  logic [7:0]        star_index_i,
  input  logic signed [8:0] new_x_i,
  input  logic signed [8:0] new_y_i,
  input  logic [9:0]        new_depth_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [17:0]       pixel_address_i,
  input  logic [15:0]       pixel_color_i,
  input  logic              pixel_visible_i,
  output int                fail_count_o,
  output int                pending_o
);

  int             star_x [ssp_pkg::STAR_COUNT];
  int             star_y [ssp_pkg::STAR_COUNT];
  int             star_z [ssp_pkg::STAR_COUNT];
  logic [9:0]     width_q;
  logic [9:0]     height_q;
  ssp_pkg::res_t  pixel_q [$];

  function automatic ssp_pkg::res_t project_star(ssp_pkg::op_e op, int idx, int nx, int ny,
                                                 int nz);
    ssp_pkg::res_t r;
    longint  w;
    longint  h;
    longint  sx;
    longint  sy;
    longint  bright;
    logic [7:0] b;
    r = '0;
    w = width_q;
    h = height_q;
    if (op == ssp_pkg::OP_LOAD) begin
      star_x[idx] = nx;
      star_y[idx] = ny;
      star_z[idx] = nz;
      return r;
    end
    star_z[idx] = star_z[idx] - 1;
    if (star_z[idx] <= 0) begin
      star_x[idx] = nx;
      star_y[idx] = ny;
      star_z[idx] = int'(width_q);
    end
    if (star_z[idx] <= 0) return r;
    sx = ((longint'(star_x[idx]) * w) / 2) / longint'(star_z[idx]) + w / 2;
    sy = ((longint'(star_y[idx]) * w) / 2) / longint'(star_z[idx]) + h / 2;
    if (w >= 2) bright = 255 - ((longint'(star_z[idx]) - 1) * 235) / (w - 1);
    else bright = 255;
    b = bright[7:0];
    if (sx < 0 || sx >= w || sy < 0 || sy >= h) return r;
    r.addr  = 18'(sx + sy * w);
    r.color = 16'({b[7:3], 11'd0} | {5'd0, b[7:2], 5'd0} | {11'd0, b[7:3]});
    r.vis   = 1'b1;
    return r;
  endfunction

  assign pending_o = pixel_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    ssp_pkg::res_t exp_px;
    if (!rst_ni) begin
      width_q      <= 10'd240;
      height_q     <= 10'd320;
      fail_count_o <= 0;
      pixel_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (ssp_pkg::reg_e'(paddr[2]) == ssp_pkg::REG_WIDTH) width_q <= pwdata[9:0];
        else height_q <= pwdata[9:0];
      end
      if (in_valid_i && !in_stall_i)
        pixel_q.push_back(project_star(ssp_pkg::op_e'(operation_i), star_index_i,
                                       new_x_i, new_y_i, new_depth_i));
      if (out_valid_i && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel transaction addr %0d", pixel_address_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_px = pixel_q.pop_front();
          if (exp_px.addr !== pixel_address_i || exp_px.color !== pixel_color_i ||
              exp_px.vis !== pixel_visible_i) begin
            if (exp_px.addr !== pixel_address_i)
              $error("pixel_address expected %0d actual %0d", exp_px.addr, pixel_address_i);
            if (exp_px.color !== pixel_color_i)
              $error("pixel_color expected %h actual %h", exp_px.color, pixel_color_i);
            if (exp_px.vis !== pixel_visible_i)
              $error("pixel_visible expected %0d actual %0d", exp_px.vis, pixel_visible_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: star projector testbench
// Drives directed and random star loads and advances under several screen
// sizes, with random idling on both channels and one long output hold-off;
// the checker predicts every pixel and reports the failures.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 400000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              operation_i = 1'b0;
  logic [7:0]        star_index_i = '0;
  logic signed [8:0] new_x_i = '0;
  logic signed [8:0] new_y_i = '0;
  logic [9:0]        new_depth_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [17:0]       pixel_address_o;
  logic [15:0]       pixel_color_o;
  logic              pixel_visible_o;

  int   fail_count;
  int   pixels_pending;
  int   cycle_count = 0;
  bit   no_idle = 1'b0;
  bit   hold_off_req = 1'b0;
  bit   loaded [ssp_pkg::STAR_COUNT];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  starfield_star_projector u_dut (.*);

  ssp_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .star_index_i,
    .new_x_i, .new_y_i, .new_depth_i, .out_valid_i(out_valid_o), .out_stall_i,
    .pixel_address_i(pixel_address_o), .pixel_color_i(pixel_color_o),
    .pixel_visible_i(pixel_visible_o), .fail_count_o(fail_count),
    .pending_o(pixels_pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int hold_cycles;
    hold_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && hold_cycles == 0) hold_cycles = 300;
      if (hold_cycles > 0) begin
        hold_cycles--;
        if (hold_cycles == 0) hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(99) < 21);
      end
    end
  end

  task automatic write_reg(ssp_pkg::reg_e r, logic [9:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {$urandom_range(0, 1) ? 22'h3FFFFF : 22'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_star(ssp_pkg::op_e op, int idx, int nx, int ny, int nz);
    bit stalled;
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    star_index_i <= idx[7:0];
    new_x_i      <= nx[8:0];
    new_y_i      <= ny[8:0];
    new_depth_i  <= nz[9:0];
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    if (op == ssp_pkg::OP_LOAD) loaded[idx] = 1'b1;
    while (!no_idle && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixels_pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_stars(int count);
    int idx;
    int nz;
    repeat (count) begin
      idx = $urandom_range(0, 99) < 60 ? $urandom_range(0, 15) : $urandom_range(0, 255);
      if (loaded[idx] && $urandom_range(99) < 70) begin
        send_star(ssp_pkg::OP_ADVANCE, idx, $urandom, $urandom, $urandom);
      end else begin
        case ($urandom_range(0, 3))
          0: nz = $urandom_range(0, 3);
          1: nz = $urandom_range(1, 1023);
          default: nz = $urandom_range(1, 512);
        endcase
        send_star(ssp_pkg::OP_LOAD, idx, $urandom, $urandom, nz);
      end
    end
  endtask

  initial begin
    int widths [7]  = '{240, 16, 512, 1023, 0, 1, 100};
    int heights [7] = '{320, 16, 512, 1023, 5, 40, 60};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_star(ssp_pkg::OP_LOAD, 0, -256, -256, 1);
    send_star(ssp_pkg::OP_ADVANCE, 0, 255, 255, 0);
    send_star(ssp_pkg::OP_ADVANCE, 0, 0, 0, 0);
    send_star(ssp_pkg::OP_LOAD, 255, 255, 255, 1023);
    send_star(ssp_pkg::OP_ADVANCE, 255, 0, 0, 0);
    send_star(ssp_pkg::OP_LOAD, 1, 0, 0, 0);
    send_star(ssp_pkg::OP_ADVANCE, 1, 5, -7, 0);
    send_star(ssp_pkg::OP_LOAD, 2, 0, 0, 240);
    send_star(ssp_pkg::OP_ADVANCE, 2, 0, 0, 1023);
    send_star(ssp_pkg::OP_LOAD, 3, 1, -1, 2);
    send_star(ssp_pkg::OP_ADVANCE, 3, 0, 0, 0);
    send_star(ssp_pkg::OP_ADVANCE, 3, -256, 255, 0);
    send_star(ssp_pkg::OP_LOAD, 128, 170, -171, 512);
    send_star(ssp_pkg::OP_ADVANCE, 128, 85, 86, 341);
    send_star(ssp_pkg::OP_LOAD, 4, -1, 0, 241);
    send_star(ssp_pkg::OP_ADVANCE, 4, 0, 0, 0);
    drain();

    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        write_reg(ssp_pkg::REG_WIDTH, 10'(widths[p]));
        write_reg(ssp_pkg::REG_HEIGHT, 10'(heights[p]));
      end
      no_idle = (p == 2);
      if (p == 1) hold_off_req = 1'b1;
      random_stars(170);
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
